@@ hw/rtl/cpf_pkg.sv @@
// Package for the collision pair filter: function and verdict codes,
// register indexes, register reset values and parameter defaults.
// No dependencies.
package cpf_pkg;

  localparam int CPF_NUM_LAYERS_DEF        = 64;
  localparam int CPF_NUM_SUBFIELDS_DEF     = 32;
  localparam int CPF_EXCEPTION_LAYER_DEF   = 5;
  localparam int CPF_ADJACENT_DISTANCE_DEF = 1;

  localparam int CPF_ROW_BITS_W  = 64;
  localparam int CPF_SUB_ROW_W   = 32;
  localparam int CPF_WORD_W      = 32;

  typedef enum logic [1:0] {
    FUNC_EVAL       = 2'd0,
    FUNC_LOAD_LAYER = 2'd1,
    FUNC_LOAD_SUB   = 2'd2
  } func_t;

  localparam logic [1:0] VERDICT_NO    = 2'd0;
  localparam logic [1:0] VERDICT_YES   = 2'd1;
  localparam logic [1:0] VERDICT_UNDEF = 2'd2;

  localparam logic [2:0] REG_LAYER_MASK       = 3'd0;
  localparam logic [2:0] REG_SUBFIELD_MASK    = 3'd1;
  localparam logic [2:0] REG_DISABLE_BIT      = 3'd2;
  localparam logic [2:0] REG_ALT_RULE_BIT     = 3'd3;
  localparam logic [2:0] REG_GROUP_SHIFT      = 3'd4;
  localparam logic [2:0] REG_SUBFIELD_SHIFT   = 3'd5;
  localparam logic [2:0] REG_BIPED_LAYER      = 3'd6;
  localparam logic [2:0] REG_DEAD_BIPED_LAYER = 3'd7;

  localparam logic [31:0] RST_LAYER_MASK       = 32'd127;
  localparam logic [31:0] RST_SUBFIELD_MASK    = 32'd31;
  localparam logic [31:0] RST_DISABLE_BIT      = 32'd16384;
  localparam logic [31:0] RST_ALT_RULE_BIT     = 32'd32768;
  localparam logic [4:0]  RST_GROUP_SHIFT      = 5'd16;
  localparam logic [4:0]  RST_SUBFIELD_SHIFT   = 5'd8;
  localparam logic [31:0] RST_BIPED_LAYER      = 32'd8;
  localparam logic [31:0] RST_DEAD_BIPED_LAYER = 32'd32;

  // Decision flags carried from the table read stage to the verdict stage.
  typedef struct packed {
    logic       cfg_bad;
    logic       layer_oob;
    logic       disabled;
    logic       group_zero;
    logic       sub_oob;
    logic       same_group;
    logic       both_live_biped;
    logic       both_biped;
    logic       alt_rule;
    logic       adjacent;
    logic [5:0] layer_bit_idx;
    logic [4:0] sub_bit_idx;
  } eval_flags_t;

endpackage

@@ hw/rtl/collision_pair_filter_unit.sv @@
// Collision pair filter top level: pipeline, layer-pair and subfield-pair
// table memories and configuration registers. Depends on cpf_pkg.
//
// Usage: an item is taken at a rising edge with start high and busy low;
// busy is never raised, so one item may be issued every cycle. func selects
// evaluation of the pair first_word/second_word, or a load of row_bits into
// row row_index of the layer-pair or subfield-pair table. Load items give no
// result. An evaluation answers on verdict with done high for one cycle,
// after the registered transaction, the table read and the result register;
// results come out in issue order. Throughput is one item per cycle: each
// table is read or written once per item, in the cycle after the item is taken, so items never contend.
// The receiver cannot stall; verdicts must be taken when done is high.
// Configuration is written on cfg_we/cfg_index/cfg_data while the block is
// idle. Synchronous reset restores the register defaults and clears the
// per-row valid bits, so both tables read as all zero straight away.
module collision_pair_filter_unit
  import cpf_pkg::*;
#(
  parameter int NUM_LAYERS        = CPF_NUM_LAYERS_DEF,
  parameter int NUM_SUBFIELDS     = CPF_NUM_SUBFIELDS_DEF,
  parameter int EXCEPTION_LAYER   = CPF_EXCEPTION_LAYER_DEF,
  parameter int ADJACENT_DISTANCE = CPF_ADJACENT_DISTANCE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] first_word,
  input  logic [31:0] second_word,
  input  logic [5:0]  row_index,
  input  logic [63:0] row_bits,
  output logic        done,
  output logic [1:0]  verdict,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LAW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int SAW = (NUM_SUBFIELDS > 1) ? $clog2(NUM_SUBFIELDS) : 1;

  // Configuration registers.
  logic [31:0] layer_mask, subfield_mask, disable_bit, alternate_rule_bit;
  logic [4:0]  group_shift, subfield_shift;
  logic [31:0] biped_layer, dead_biped_layer;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_mask         <= RST_LAYER_MASK;
      subfield_mask      <= RST_SUBFIELD_MASK;
      disable_bit        <= RST_DISABLE_BIT;
      alternate_rule_bit <= RST_ALT_RULE_BIT;
      group_shift        <= RST_GROUP_SHIFT;
      subfield_shift     <= RST_SUBFIELD_SHIFT;
      biped_layer        <= RST_BIPED_LAYER;
      dead_biped_layer   <= RST_DEAD_BIPED_LAYER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYER_MASK:       layer_mask         <= cfg_data;
        REG_SUBFIELD_MASK:    subfield_mask      <= cfg_data;
        REG_DISABLE_BIT:      disable_bit        <= cfg_data;
        REG_ALT_RULE_BIT:     alternate_rule_bit <= cfg_data;
        REG_GROUP_SHIFT:      group_shift        <= cfg_data[4:0];
        REG_SUBFIELD_SHIFT:   subfield_shift     <= cfg_data[4:0];
        REG_BIPED_LAYER:      biped_layer        <= cfg_data;
        REG_DEAD_BIPED_LAYER: dead_biped_layer   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: registered transaction.
  logic        p1_valid;
  logic [1:0]  p1_func;
  logic [31:0] p1_w1, p1_w2;
  logic [5:0]  p1_row;
  logic [63:0] p1_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= start && !busy;
    end
    p1_func <= func;
    p1_w1   <= first_word;
    p1_w2   <= second_word;
    p1_row  <= row_index;
    p1_bits <= row_bits;
  end

  // Field extraction and rule flags.
  logic [31:0] l1, l2, g1, g2, s1, s2;
  logic [4:0]  s1n, s2n, sdiff;
  eval_flags_t flags;
  logic [LAW-1:0] layer_raddr;
  logic [SAW-1:0] sub_raddr;

  always_comb begin
    l1 = p1_w1 & layer_mask;
    l2 = p1_w2 & layer_mask;
    g1 = p1_w1 >> group_shift;
    g2 = p1_w2 >> group_shift;
    s1 = (p1_w1 >> subfield_shift) & subfield_mask;
    s2 = (p1_w2 >> subfield_shift) & subfield_mask;
    s1n = s1[4:0];
    s2n = s2[4:0];
    sdiff = (s1n >= s2n) ? (s1n - s2n) : (s2n - s1n);

    flags.cfg_bad = (layer_mask == '0) || (subfield_mask == '0) ||
                    (disable_bit == '0) || (alternate_rule_bit == '0) ||
                    ((6'(group_shift) + 6'(subfield_shift)) >= 6'd32);
    flags.layer_oob = (l1 >= 32'(NUM_LAYERS)) || (l2 >= 32'(NUM_LAYERS));
    flags.disabled = (l1 != 32'(EXCEPTION_LAYER)) &&
                     (((p1_w1 | p1_w2) & disable_bit) != '0);
    flags.group_zero = (g1 == '0) || (g2 == '0);
    flags.sub_oob = (s1 >= 32'(NUM_SUBFIELDS)) || (s2 >= 32'(NUM_SUBFIELDS));
    flags.same_group = (g1 == g2);
    flags.both_live_biped = (l1 == biped_layer) && (l2 == biped_layer);
    flags.both_biped = ((l1 == biped_layer) || (l1 == dead_biped_layer)) &&
                       ((l2 == biped_layer) || (l2 == dead_biped_layer));
    flags.alt_rule = (p1_w1 & p1_w2 & alternate_rule_bit) != '0;
    flags.adjacent = (sdiff == 5'(ADJACENT_DISTANCE));
    flags.layer_bit_idx = l2[5:0];
    flags.sub_bit_idx = s2n;

    // Out-of-range indices would address beyond the memory; their verdict
    // does not depend on the data read.
    layer_raddr = flags.layer_oob ? '0 : l1[LAW-1:0];
    sub_raddr   = (flags.sub_oob || flags.layer_oob) ? '0 : s1[SAW-1:0];
  end

  // Table memories. Each item uses its stage-1 cycle for either a read or a
  // write, so a read never meets a write of another item in the same cycle.
  logic [63:0] layer_mem [NUM_LAYERS];
  logic [31:0] sub_mem   [NUM_SUBFIELDS];
  logic [NUM_LAYERS-1:0]    layer_vld;
  logic [NUM_SUBFIELDS-1:0] sub_vld;
  logic [63:0] layer_q;
  logic [31:0] sub_q;
  logic        layer_q_vld, sub_q_vld;
  logic        wr_layer, wr_sub;

  assign wr_layer = p1_valid && (p1_func == FUNC_LOAD_LAYER) &&
                    (7'(p1_row) < 7'(NUM_LAYERS));
  assign wr_sub   = p1_valid && (p1_func == FUNC_LOAD_SUB) &&
                    (7'(p1_row) < 7'(NUM_SUBFIELDS));

  always_ff @(posedge clk) begin
    if (wr_layer) begin
      layer_mem[p1_row[LAW-1:0]] <= p1_bits;
    end
    layer_q <= layer_mem[layer_raddr];
    if (wr_sub) begin
      sub_mem[p1_row[SAW-1:0]] <= p1_bits[31:0];
    end
    sub_q <= sub_mem[sub_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_vld <= '0;
      sub_vld   <= '0;
    end else begin
      if (wr_layer) begin
        layer_vld[p1_row[LAW-1:0]] <= 1'b1;
      end
      if (wr_sub) begin
        sub_vld[p1_row[SAW-1:0]] <= 1'b1;
      end
    end
    layer_q_vld <= layer_vld[layer_raddr];
    sub_q_vld   <= sub_vld[sub_raddr];
  end

  // Stage 2: flags beside the registered read data.
  logic        p2_valid;
  eval_flags_t p2_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid && (p1_func == FUNC_EVAL);
    end
    p2_flags <= flags;
  end

  logic [63:0] layer_row;
  logic [31:0] sub_row;
  logic        layer_hit, sub_hit;
  logic [1:0]  verdict_next;

  always_comb begin
    layer_row = layer_q_vld ? layer_q : '0;
    sub_row   = sub_q_vld ? sub_q : '0;
    layer_hit = layer_row[p2_flags.layer_bit_idx];
    sub_hit   = sub_row[p2_flags.sub_bit_idx];
    priority if (p2_flags.cfg_bad || p2_flags.layer_oob) begin
      verdict_next = VERDICT_UNDEF;
    end else if (p2_flags.disabled) begin
      verdict_next = VERDICT_NO;
    end else if (p2_flags.group_zero) begin
      verdict_next = VERDICT_YES;
    end else if (p2_flags.sub_oob) begin
      verdict_next = VERDICT_UNDEF;
    end else if (p2_flags.same_group && p2_flags.both_live_biped) begin
      verdict_next = sub_hit ? VERDICT_YES : VERDICT_NO;
    end else if (!p2_flags.same_group) begin
      verdict_next = layer_hit ? VERDICT_YES : VERDICT_NO;
    end else if (p2_flags.alt_rule) begin
      verdict_next = (layer_hit && !p2_flags.adjacent) ? VERDICT_YES : VERDICT_NO;
    end else if (!p2_flags.both_biped) begin
      verdict_next = VERDICT_NO;
    end else begin
      verdict_next = sub_hit ? VERDICT_YES : VERDICT_NO;
    end
  end

  // Stage 3: result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p2_valid;
    end
    verdict <= verdict_next;
  end

endmodule
